// ===== design/sdf_pkg.sv =====
package sdf_pkg;

    // field and storage widths
    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 8;
    localparam int WIDTH_W    = 6;
    localparam int DEC_DIGITS = 10;
    localparam int DIGIT_IDX_W = $clog2(DEC_DIGITS);
    localparam int CONV_CNT_W = $clog2(VALUE_W);

    // default ceiling on the padded digit count
    localparam int MAX_WIDTH_DEF = 32;

    // register map
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_MIN_WIDTH = 1'b0;

    // ascii codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    typedef logic [DEC_DIGITS-1:0][3:0] bcd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_LEN,
        ST_SIGN,
        ST_PAD,
        ST_DIGIT
    } state_t;

    // handshake from the converter back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } conv_stat_t;

endpackage

// ===== design/sdf_bcd_conv.sv =====
module sdf_bcd_conv
    import sdf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VALUE_W-1:0] mag,
    output conv_stat_t         stat,
    output bcd_t               bcd
);

    logic [VALUE_W-1:0]    bin_reg, bin_next;
    bcd_t                  bcd_reg, bcd_next;
    logic [CONV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    bcd_t                  adj;
    logic [DEC_DIGITS*4+VALUE_W-1:0] shifted;

    // one shift-add-3 step: correct every digit, then shift one bit in
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
        shifted = {adj, bin_reg} << 1;
    end

    // step sequencing
    always_comb begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            bin_next  = mag;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            bin_next = shifted[VALUE_W-1:0];
            bcd_next = shifted[DEC_DIGITS*4+VALUE_W-1:VALUE_W];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CONV_CNT_W'(VALUE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign bcd       = bcd_reg;

endmodule

// ===== design/signed_decimal_formatter_core.sv =====
// channel   | ports                        | contents
// ----------+------------------------------+-------------------------------------
// input     | s_tvalid s_tready s_tdata    | tdata[31:0] value (signed)
// output    | m_tvalid m_tready m_tdata    | tdata[7:0] text_char, tlast last
// config    | apb psel .. prdata           | 0x0 min_width[5:0]
//
// an item is accepted, converted by the shift-add-3 unit, then passes the done
// pulse and the length step; the characters then follow at one per cycle
// (1 to max(MAX_WIDTH,10)+1 characters) when the output side keeps taking requests.
// s_tready is high only while idle; the output register holds a character
// until it is taken, and a stall on m_tready halts the character sequencer.
// reset is synchronous, active low; min_width resets to 0.
module signed_decimal_formatter_core
    import sdf_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input request
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic signed [VALUE_W-1:0] s_tdata,   // [31:0] value
    // output request
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CHAR_W-1:0]     m_tdata,       // [7:0] text_char
    output logic                  m_tlast,       // last
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    state_t                 state_reg, state_next;
    logic [WIDTH_W-1:0]     min_width_reg;
    logic                   neg_reg, neg_next;
    logic [WIDTH_W-1:0]     pad_reg, pad_next;
    logic [DIGIT_IDX_W-1:0] idx_reg, idx_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [CHAR_W-1:0]      m_tdata_reg, m_tdata_next;
    logic                   m_tlast_reg, m_tlast_next;

    logic                   accept;
    logic                   out_free;
    logic                   conv_start;
    logic [VALUE_W-1:0]     mag;
    conv_stat_t             conv_stat;
    bcd_t                   bcd;
    logic [DIGIT_IDX_W-1:0] top_idx;
    logic [WIDTH_W-1:0]     ndig;
    logic [WIDTH_W-1:0]     width_sat;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_WIDTH)
                  ? {{(APB_DATA_W-WIDTH_W){1'b0}}, min_width_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_width_reg <= '0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_MIN_WIDTH) begin
            min_width_reg <= pwdata[WIDTH_W-1:0];
        end
    end

    // input side and magnitude
    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign conv_start = accept;
    assign mag        = s_tdata[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(s_tdata))
                                           : VALUE_W'(s_tdata);

    sdf_bcd_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (conv_start),
        .mag     (mag),
        .stat    (conv_stat),
        .bcd     (bcd)
    );

    // most significant nonzero digit, at least one digit
    always_comb begin
        top_idx = '0;
        for (int i = 1; i < DEC_DIGITS; i++) begin
            if (bcd[i] != 4'd0) begin
                top_idx = DIGIT_IDX_W'(i);
            end
        end
        ndig = WIDTH_W'(top_idx) + 1'b1;
    end

    assign width_sat = (min_width_reg > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH)
                                                             : min_width_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    // character sequencer
    always_comb begin
        state_next    = state_reg;
        neg_next      = neg_reg;
        pad_next      = pad_reg;
        idx_next      = idx_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    neg_next   = s_tdata[VALUE_W-1];
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (conv_stat.done) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                pad_next = (width_sat > ndig) ? width_sat - ndig : '0;
                idx_next = top_idx;
                if (neg_reg) begin
                    state_next = ST_SIGN;
                end else if (width_sat > ndig) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_DIGIT;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = CHAR_MINUS;
                    m_tlast_next  = 1'b0;
                    state_next    = (pad_reg != '0) ? ST_PAD : ST_DIGIT;
                end
            end
            ST_PAD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = CHAR_ZERO;
                    m_tlast_next  = 1'b0;
                    pad_next      = pad_reg - 1'b1;
                    if (pad_reg == WIDTH_W'(1)) begin
                        state_next = ST_DIGIT;
                    end
                end
            end
            ST_DIGIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = CHAR_ZERO + CHAR_W'(bcd[idx_reg]);
                    m_tlast_next  = (idx_reg == '0);
                    idx_next      = idx_reg - 1'b1;
                    if (idx_reg == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        neg_reg     <= neg_next;
        pad_reg     <= pad_next;
        idx_reg     <= idx_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule
